// File: rtl/core/gtm_pkg.sv
// gtm_pkg: shared types, widths and constants of the gesture template matcher
// used by every module of the block, no dependencies of its own

package gtm_pkg;

    // default sizing of the reference table
    localparam int NUM_REFS_DEF     = 32;
    localparam int MAX_SEGMENTS_DEF = 16;

    // field widths fixed by the item layout
    localparam int OP_W        = 2;
    localparam int REF_IN_W    = 5;
    localparam int SEG_IN_W    = 4;
    localparam int DIR_W       = 9;
    localparam int LEN_W       = 10;
    localparam int DTOL_W      = 8;
    localparam int LTOL_W      = 10;
    localparam int RCFG_W      = 6;
    localparam int SEGCNT_W    = 5;
    localparam int SCORE_W     = 20;
    localparam int TERM_W      = 15;
    localparam int OUT_REF_W   = 5;
    localparam int OUT_CNT_W   = 5;
    localparam int REF_TAG_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    // arithmetic constants
    localparam logic [DIR_W-1:0]   DEG_FULL   = 9'd360;
    localparam logic [TERM_W-1:0]  DIR_WEIGHT = 15'd100;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 20'hFFFFF;

    // register reset values
    localparam logic [DTOL_W-1:0] DIR_TOL_RST   = 8'd20;
    localparam logic [LTOL_W-1:0] LEN_TOL_RST   = 10'd200;
    localparam logic [RCFG_W-1:0] REF_COUNT_RST = 6'd0;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_APPEND = 2'd1,
        OP_MATCH  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_TOL   = 2'd0,
        CFG_LEN_TOL   = 2'd1,
        CFG_REF_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // one segment comparison issued to the scorer
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic [REF_TAG_W-1:0] ref_id;
    } t_seg_tag;

    // verdict on one reference after its last segment
    typedef struct packed {
        logic                 valid;
        logic                 pass;
        logic [REF_TAG_W-1:0] ref_id;
        logic [SCORE_W-1:0]   score;
    } t_ref_done;

endpackage

// File: rtl/core/gtm_ref_mem.sv
// gtm_ref_mem: reference segment memory with registered read, plus the
// per-reference segment counts in reset flops; depends on gtm_pkg

module gtm_ref_mem
    import gtm_pkg::*;
#(
    parameter int NUM_REFS     = NUM_REFS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [$clog2(NUM_REFS*MAX_SEGMENTS > 1 ? NUM_REFS*MAX_SEGMENTS : 2)-1:0] i_wr_addr,
    input  logic [DIR_W-1:0]     i_wr_dir,
    input  logic [LEN_W-1:0]     i_wr_len,
    input  logic                 i_cnt_wr,
    input  logic [$clog2(NUM_REFS > 1 ? NUM_REFS : 2)-1:0] i_cnt_wr_idx,
    input  logic [SEGCNT_W-1:0]  i_cnt_val,
    input  logic [$clog2(NUM_REFS*MAX_SEGMENTS > 1 ? NUM_REFS*MAX_SEGMENTS : 2)-1:0] i_rd_addr,
    output logic [DIR_W-1:0]     o_rd_dir,
    output logic [LEN_W-1:0]     o_rd_len,
    input  logic [$clog2(NUM_REFS > 1 ? NUM_REFS : 2)-1:0] i_cnt_rd_idx,
    output logic [SEGCNT_W-1:0]  o_cnt
);

    localparam int DEPTH = NUM_REFS * MAX_SEGMENTS;

    logic [DIR_W+LEN_W-1:0] r_mem [DEPTH];
    logic [DIR_W+LEN_W-1:0] r_rd_word;
    logic [SEGCNT_W-1:0]    r_cnt [NUM_REFS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_dir, i_wr_len};
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    assign o_rd_dir = r_rd_word[DIR_W+LEN_W-1:LEN_W];
    assign o_rd_len = r_rd_word[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REFS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cnt_wr) begin
            r_cnt[i_cnt_wr_idx] <= i_cnt_val;
        end
    end

    assign o_cnt = r_cnt[i_cnt_rd_idx];

endmodule

// File: rtl/core/gtm_cand_mem.sv
// gtm_cand_mem: candidate segment store, one write and one registered read
// per cycle; depends on gtm_pkg

module gtm_cand_mem
    import gtm_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [$clog2(MAX_SEGMENTS > 1 ? MAX_SEGMENTS : 2)-1:0] i_wr_idx,
    input  logic [DIR_W-1:0]     i_wr_dir,
    input  logic [LEN_W-1:0]     i_wr_len,
    input  logic [$clog2(MAX_SEGMENTS > 1 ? MAX_SEGMENTS : 2)-1:0] i_rd_idx,
    output logic [DIR_W-1:0]     o_rd_dir,
    output logic [LEN_W-1:0]     o_rd_len
);

    logic [DIR_W+LEN_W-1:0] r_mem [MAX_SEGMENTS];
    logic [DIR_W+LEN_W-1:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_dir, i_wr_len};
        end
        r_rd_word <= r_mem[i_rd_idx];
    end

    assign o_rd_dir = r_rd_word[DIR_W+LEN_W-1:LEN_W];
    assign o_rd_len = r_rd_word[LEN_W-1:0];

endmodule

// File: rtl/core/gtm_seg_scorer.sv
// gtm_seg_scorer: shared segment compare unit, one segment pair a cycle:
// error terms, tolerance check and saturating score accumulation; uses gtm_pkg

module gtm_seg_scorer
    import gtm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_seg_tag          i_tag,
    input  logic [DIR_W-1:0]  i_cand_dir,
    input  logic [LEN_W-1:0]  i_cand_len,
    input  logic [DIR_W-1:0]  i_ref_dir,
    input  logic [LEN_W-1:0]  i_ref_len,
    input  logic [DTOL_W-1:0] i_dir_tol,
    input  logic [LTOL_W-1:0] i_len_tol,
    output t_ref_done         o_done,
    output logic              o_busy
);

    t_seg_tag            r_t1;
    t_seg_tag            r_t2;
    logic [TERM_W-1:0]   r_t2_term;
    logic                r_t2_pass;
    logic [SCORE_W-1:0]  r_acc;
    logic                r_fail;
    t_ref_done           r_done;

    logic [DIR_W-1:0]    dir_abs;
    logic [DIR_W-1:0]    dir_mod;
    logic [DIR_W-1:0]    dir_alt;
    logic [DTOL_W-1:0]   dir_err;
    logic [LEN_W-1:0]    len_err;
    logic [DTOL_W-1:0]   dir_margin;
    logic [LTOL_W-1:0]   len_margin;
    logic [TERM_W-1:0]   term;
    logic                seg_pass;
    logic [SCORE_W-1:0]  acc_base;
    logic [SCORE_W:0]    acc_sum;
    logic [SCORE_W-1:0]  acc_sat;
    logic                fail_nxt;

    // stage 1: memory data lines up with the tag, work out errors and term
    always_comb begin
        dir_abs    = (i_cand_dir > i_ref_dir) ? (i_cand_dir - i_ref_dir)
                                              : (i_ref_dir - i_cand_dir);
        dir_mod    = (dir_abs >= DEG_FULL) ? (dir_abs - DEG_FULL) : dir_abs;
        dir_alt    = DEG_FULL - dir_mod;
        dir_err    = (dir_mod < dir_alt) ? DTOL_W'(dir_mod) : DTOL_W'(dir_alt);
        len_err    = (i_cand_len > i_ref_len) ? (i_cand_len - i_ref_len)
                                              : (i_ref_len - i_cand_len);
        seg_pass   = (dir_err <= i_dir_tol) && (len_err <= i_len_tol);
        dir_margin = i_dir_tol - dir_err;
        len_margin = i_len_tol - len_err;
        term       = TERM_W'(dir_margin) * DIR_WEIGHT + TERM_W'(len_margin);
    end

    // stage 2: accumulate, restart on the first segment of a reference
    always_comb begin
        acc_base = r_t2.first ? '0 : r_acc;
        acc_sum  = {1'b0, acc_base} + (SCORE_W+1)'(r_t2_term);
        acc_sat  = acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
        fail_nxt = (r_t2.first ? 1'b0 : r_fail) | ~r_t2_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1         <= '0;
            r_t2         <= '0;
            r_done.valid <= 1'b0;
        end else begin
            r_t1         <= i_tag;
            r_t2         <= r_t1;
            r_done.valid <= r_t2.valid & r_t2.last;
        end
        r_t2_term <= term;
        r_t2_pass <= seg_pass;
        if (r_t2.valid) begin
            r_acc  <= acc_sat;
            r_fail <= fail_nxt;
        end
        r_done.pass   <= ~fail_nxt;
        r_done.score  <= acc_sat;
        r_done.ref_id <= r_t2.ref_id;
    end

    assign o_done = r_done;
    assign o_busy = r_t1.valid | r_t2.valid | r_done.valid;

endmodule

// File: rtl/core/gesture_template_matcher_unit.sv
// gesture_template_matcher_unit: top level, sequencer, config registers,
// candidate bookkeeping and result register; uses gtm_pkg, gtm_ref_mem,
// gtm_cand_mem and gtm_seg_scorer
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  -----------------------------------------
//  s        in   i_s_tvalid / o_s_tready   tuser operation, tdata load/append fields,
//                                          tlast ref_last
//  m        out  o_m_tvalid / i_m_tready   tuser found/overflowed, tdata best match
//  cfg      in   i_cfg_wen                 i_cfg_index, i_cfg_wdata
//
// load and append items give no result and leave the input side ready
// a match scans the references in use in order: one whose segment count agrees with
// the candidate's is compared segment by segment in the shared segment scorer, fed
// through the single read port of the reference memory, any other is skipped; then
// drain waits for the scorer to empty and the result register is loaded
// a match with an overflowed candidate skips the scan and drain and goes to the result load
// the input side is ready only while idle; a pending result blocks only the end
// of the next match, loads and appends are still taken
// synchronous active-low reset, no clearing pass: reference segment counts live
// in reset flops, segment data is undefined until loaded

module gesture_template_matcher_unit
    import gtm_pkg::*;
#(
    parameter int NUM_REFS     = NUM_REFS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream: load, append and match items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: ref_index[4:0], seg_index[8:5], direction[17:9], seg_length[27:18], zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]       i_s_tuser,
    input  logic                  i_s_tlast,
    // master stream: one item per match
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: best_ref[4:0], best_score[24:5], segment_count[29:25], zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // tuser: found[0], overflowed[1]
    output logic [M_TUSER_W-1:0]  o_m_tuser,
    // register write port
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int DEPTH  = NUM_REFS * MAX_SEGMENTS;
    localparam int AW     = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int RIDX_W = $clog2(NUM_REFS > 1 ? NUM_REFS : 2);
    localparam int RCNT_W = $clog2(NUM_REFS + 1);
    localparam int SIDX_W = $clog2(MAX_SEGMENTS > 1 ? MAX_SEGMENTS : 2);
    localparam int CCNT_W = $clog2(MAX_SEGMENTS + 1);

    // input item fields
    logic [REF_IN_W-1:0] in_ref;
    logic [SEG_IN_W-1:0] in_seg;
    logic [DIR_W-1:0]    in_dir;
    logic [LEN_W-1:0]    in_len;
    logic                s_accept;

    assign in_ref   = i_s_tdata[4:0];
    assign in_seg   = i_s_tdata[8:5];
    assign in_dir   = i_s_tdata[17:9];
    assign in_len   = i_s_tdata[27:18];
    assign s_accept = i_s_tvalid & o_s_tready;

    // configuration registers
    logic [DTOL_W-1:0] r_dir_tol;
    logic [LTOL_W-1:0] r_len_tol;
    logic [RCFG_W-1:0] r_ref_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_tol   <= DIR_TOL_RST;
            r_len_tol   <= LEN_TOL_RST;
            r_ref_count <= REF_COUNT_RST;
        end else if (i_cfg_wen) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DIR_TOL:   r_dir_tol   <= i_cfg_wdata[DTOL_W-1:0];
                CFG_LEN_TOL:   r_len_tol   <= i_cfg_wdata[LTOL_W-1:0];
                CFG_REF_COUNT: r_ref_count <= i_cfg_wdata[RCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and bookkeeping state
    t_state              r_state, n_state;
    logic [CCNT_W-1:0]   r_cand_count, n_cand_count;
    logic                r_cand_ovf, n_cand_ovf;
    logic [RCNT_W-1:0]   r_ref, n_ref;
    logic [RCNT_W-1:0]   r_ref_lim, n_ref_lim;
    logic [SIDX_W-1:0]   r_seg, n_seg;
    logic                r_found, n_found;
    logic [RIDX_W-1:0]   r_best_ref, n_best_ref;
    logic [SCORE_W-1:0]  r_best_score, n_best_score;
    // result register
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [OUT_REF_W-1:0] r_out_ref, n_out_ref;
    logic [SCORE_W-1:0]  r_out_score, n_out_score;
    logic [OUT_CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic                r_out_ovf, n_out_ovf;

    // memory and scorer hookup
    logic                ref_wr;
    logic                cnt_wr;
    logic                cand_wr;
    logic                cand_room;
    logic [AW-1:0]       ref_wr_addr;
    logic [AW-1:0]       ref_rd_addr;
    logic [DIR_W-1:0]    ref_rd_dir;
    logic [LEN_W-1:0]    ref_rd_len;
    logic [DIR_W-1:0]    cand_rd_dir;
    logic [LEN_W-1:0]    cand_rd_len;
    logic [SEGCNT_W-1:0] ref_cnt;
    logic                cnt_match;
    t_seg_tag            issue;
    t_ref_done           done;
    logic                scorer_busy;
    logic                direct_hit;
    logic                hit_v;
    logic [RIDX_W-1:0]   hit_ref;
    logic [SCORE_W-1:0]  hit_score;
    logic [RCNT_W-1:0]   ref_lim;

    // load is dropped when it points outside the table
    assign ref_wr = s_accept && (t_op'(i_s_tuser) == OP_LOAD)
                 && (32'(in_ref) < NUM_REFS) && (32'(in_seg) < MAX_SEGMENTS);
    assign cnt_wr = ref_wr & i_s_tlast;
    assign ref_wr_addr = AW'(32'(in_ref) * MAX_SEGMENTS + 32'(in_seg));

    assign cand_room = 32'(r_cand_count) < MAX_SEGMENTS;
    assign cand_wr   = s_accept && (t_op'(i_s_tuser) == OP_APPEND) && cand_room;

    assign ref_rd_addr = AW'(32'(r_ref) * MAX_SEGMENTS + 32'(r_seg));
    assign cnt_match   = 32'(ref_cnt) == 32'(r_cand_count);

    // ref_count above the table size acts as the table size
    assign ref_lim = (32'(r_ref_count) < NUM_REFS) ? RCNT_W'(r_ref_count)
                                                   : RCNT_W'(NUM_REFS);

    gtm_ref_mem #(
        .NUM_REFS     (NUM_REFS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ref_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (ref_wr),
        .i_wr_addr    (ref_wr_addr),
        .i_wr_dir     (in_dir),
        .i_wr_len     (in_len),
        .i_cnt_wr     (cnt_wr),
        .i_cnt_wr_idx (RIDX_W'(in_ref)),
        .i_cnt_val    (SEGCNT_W'(in_seg) + SEGCNT_W'(1)),
        .i_rd_addr    (ref_rd_addr),
        .o_rd_dir     (ref_rd_dir),
        .o_rd_len     (ref_rd_len),
        .i_cnt_rd_idx (r_ref[RIDX_W-1:0]),
        .o_cnt        (ref_cnt)
    );

    gtm_cand_mem #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_cand_mem (
        .i_clk        (i_clk),
        .i_wr_en      (cand_wr),
        .i_wr_idx     (r_cand_count[SIDX_W-1:0]),
        .i_wr_dir     (in_dir),
        .i_wr_len     (in_len),
        .i_rd_idx     (r_seg),
        .o_rd_dir     (cand_rd_dir),
        .o_rd_len     (cand_rd_len)
    );

    gtm_seg_scorer u_scorer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (issue),
        .i_cand_dir   (cand_rd_dir),
        .i_cand_len   (cand_rd_len),
        .i_ref_dir    (ref_rd_dir),
        .i_ref_len    (ref_rd_len),
        .i_dir_tol    (r_dir_tol),
        .i_len_tol    (r_len_tol),
        .o_done       (done),
        .o_busy       (scorer_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cand_count <= '0;
            r_cand_ovf   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ref        <= '0;
            r_ref_lim    <= '0;
            r_seg        <= '0;
            r_found      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cand_count <= n_cand_count;
            r_cand_ovf   <= n_cand_ovf;
            r_out_valid  <= n_out_valid;
            r_ref        <= n_ref;
            r_ref_lim    <= n_ref_lim;
            r_seg        <= n_seg;
            r_found      <= n_found;
        end
        r_best_ref   <= n_best_ref;
        r_best_score <= n_best_score;
        r_out_found  <= n_out_found;
        r_out_ref    <= n_out_ref;
        r_out_score  <= n_out_score;
        r_out_cnt    <= n_out_cnt;
        r_out_ovf    <= n_out_ovf;
    end

    always_comb begin
        n_state      = r_state;
        n_cand_count = r_cand_count;
        n_cand_ovf   = r_cand_ovf;
        n_ref        = r_ref;
        n_ref_lim    = r_ref_lim;
        n_seg        = r_seg;
        n_found      = r_found;
        n_best_ref   = r_best_ref;
        n_best_score = r_best_score;
        n_out_valid  = r_out_valid & ~i_m_tready;
        n_out_found  = r_out_found;
        n_out_ref    = r_out_ref;
        n_out_score  = r_out_score;
        n_out_cnt    = r_out_cnt;
        n_out_ovf    = r_out_ovf;
        issue        = '0;
        direct_hit   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (t_op'(i_s_tuser))
                        OP_LOAD: ;
                        OP_APPEND: begin
                            if (cand_room) begin
                                n_cand_count = r_cand_count + CCNT_W'(1);
                            end else begin
                                n_cand_ovf = 1'b1;
                            end
                        end
                        OP_MATCH: begin
                            n_ref        = '0;
                            n_seg        = '0;
                            n_ref_lim    = ref_lim;
                            n_found      = 1'b0;
                            n_best_ref   = '0;
                            n_best_score = '0;
                            // overflowed candidate compares against nothing
                            n_state      = r_cand_ovf ? ST_FINISH : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_ref == r_ref_lim) begin
                    n_state = ST_DRAIN;
                end else if (!cnt_match) begin
                    n_ref = r_ref + RCNT_W'(1);
                end else if (r_cand_count == '0) begin
                    // empty candidate matches an empty reference with score zero
                    direct_hit = 1'b1;
                    n_ref      = r_ref + RCNT_W'(1);
                end else begin
                    issue.valid  = 1'b1;
                    issue.first  = (r_seg == '0);
                    issue.last   = (32'(r_seg) + 1) == 32'(r_cand_count);
                    issue.ref_id = REF_TAG_W'(r_ref);
                    if (issue.last) begin
                        n_seg = '0;
                        n_ref = r_ref + RCNT_W'(1);
                    end else begin
                        n_seg = r_seg + SIDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!scorer_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_found;
                    n_out_ref    = OUT_REF_W'(r_best_ref);
                    n_out_score  = r_best_score;
                    n_out_cnt    = OUT_CNT_W'(r_cand_count);
                    n_out_ovf    = r_cand_ovf;
                    n_cand_count = '0;
                    n_cand_ovf   = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // best tracker: strict greater keeps the lowest index on ties
        hit_v     = direct_hit | (done.valid & done.pass);
        hit_ref   = direct_hit ? r_ref[RIDX_W-1:0] : RIDX_W'(done.ref_id);
        hit_score = direct_hit ? '0 : done.score;
        if (hit_v && (!r_found || (hit_score > r_best_score))) begin
            n_found      = 1'b1;
            n_best_ref   = hit_ref;
            n_best_score = hit_score;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_cnt, r_out_score, r_out_ref};
    assign o_m_tuser  = {r_out_ovf, r_out_found};

endmodule

// File: rtl/core/gtm_checker.sv
// gtm_checker: port-level assertions for the gesture template matcher top,
// attached by bind; uses gtm_pkg

module gtm_checker
    import gtm_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [OP_W-1:0]       i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata,
    input logic [M_TUSER_W-1:0]  o_m_tuser
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result item changed while stalled");

    // no match means zero index and zero score
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[24:0] == 25'd0)
        else $error("no-match item carries index or score");

    // overflowed candidate never matches and reports a full store
    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> !o_m_tuser[0]
                                       && o_m_tdata[29:25] == 5'(MAX_SEGMENTS))
        else $error("overflowed match reported a hit or wrong count");

    // a match occupies the block, loads and appends do not
    a_match_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_MATCH |=> !o_s_tready)
        else $error("ready right after accepting a match");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_LOAD || i_s_tuser == OP_APPEND)
        |=> o_s_tready)
        else $error("not ready after a load or append");

endmodule

bind gesture_template_matcher_unit gtm_checker #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
) u_gtm_checker (.*);
